// ===== rtl/core/ogu_pkg.sv =====
// ----------------------------------------------------------------------------
// ogu_pkg
// Shared types, codes and constants of the occupancy grid log-odds updater.
// ----------------------------------------------------------------------------
package ogu_pkg;

   // Default sizing of the cell store
   localparam int MAP_CELLS_DEFAULT = 65536;
   localparam int LOG_WIDTH_DEFAULT = 16;

   // Fixed field widths
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int PCT_W       = 7;
   localparam int EDGE_W      = 16;

   // Beam end offset, 0.1 m in Q8.8
   localparam logic [16:0] BEAM_OFFSET = 17'd26;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SENSOR_RANGE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OCCUPIED_BAND = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SELF_RADIUS   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOG_INITIAL   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOG_OCCUPIED  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOG_FREE      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD     = 3'd6;

   // Configuration reset values
   localparam logic [15:0]        RST_SENSOR_RANGE  = 16'd2560;
   localparam logic [15:0]        RST_OCCUPIED_BAND = 16'd36;
   localparam logic [15:0]        RST_SELF_RADIUS   = 16'd102;
   localparam logic signed [15:0] RST_LOG_INITIAL   = 16'sd0;
   localparam logic signed [15:0] RST_LOG_OCCUPIED  = 16'sd218;
   localparam logic signed [15:0] RST_LOG_FREE      = -16'sd218;
   localparam logic [PCT_W-1:0]   RST_THRESHOLD     = 7'd50;

   // Result region codes
   localparam logic [1:0] REGION_OUT    = 2'd0;
   localparam logic [1:0] REGION_BODY   = 2'd1;
   localparam logic [1:0] REGION_UPDATE = 2'd2;
   localparam logic [1:0] REGION_INIT   = 2'd3;

   // Percent table size and the highest percent
   localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

   // Least Q.8 log-odds that reaches each percent step; last entry saturates
   localparam logic signed [EDGE_W-1:0] PCT_EDGE [100] = '{
      -16'sd1176, -16'sd996, -16'sd889, -16'sd813, -16'sd753,
      -16'sd704, -16'sd662, -16'sd625, -16'sd592, -16'sd562,
      -16'sd535, -16'sd510, -16'sd486, -16'sd464, -16'sd444,
      -16'sd424, -16'sd405, -16'sd388, -16'sd371, -16'sd354,
      -16'sd339, -16'sd324, -16'sd309, -16'sd295, -16'sd281,
      -16'sd267, -16'sd254, -16'sd241, -16'sd229, -16'sd216,
      -16'sd204, -16'sd192, -16'sd181, -16'sd169, -16'sd158,
      -16'sd147, -16'sd136, -16'sd125, -16'sd114, -16'sd103,
      -16'sd93, -16'sd82, -16'sd72, -16'sd61, -16'sd51,
      -16'sd41, -16'sd30, -16'sd20, -16'sd10, 16'sd0,
      16'sd11, 16'sd21, 16'sd31, 16'sd42, 16'sd52,
      16'sd62, 16'sd73, 16'sd83, 16'sd94, 16'sd104,
      16'sd115, 16'sd126, 16'sd137, 16'sd148, 16'sd159,
      16'sd170, 16'sd182, 16'sd193, 16'sd205, 16'sd217,
      16'sd230, 16'sd242, 16'sd255, 16'sd268, 16'sd282,
      16'sd296, 16'sd310, 16'sd325, 16'sd340, 16'sd355,
      16'sd372, 16'sd389, 16'sd406, 16'sd425, 16'sd445,
      16'sd465, 16'sd487, 16'sd511, 16'sd536, 16'sd563,
      16'sd593, 16'sd626, 16'sd663, 16'sd705, 16'sd754,
      16'sd814, 16'sd890, 16'sd997, 16'sd1177, 16'sd9583
   };

   // Look up one percent edge; codes past the table read the top entry
   function automatic logic signed [EDGE_W-1:0] pct_edge_at(input logic [PCT_W-1:0] idx);
      logic signed [EDGE_W-1:0] val;
      if (idx < PCT_MAX) begin
         val = PCT_EDGE[idx];
      end else begin
         val = PCT_EDGE[99];
      end
      return val;
   endfunction

   // Commands from the controller to the datapath
   typedef struct packed {
      logic             capture;
      logic             mod_mul;
      logic             mod_qm;
      logic             mod_sub;
      logic             mem_read;
      logic             apply;
      logic             search;
      logic [2:0]       search_bit;
      logic             out_load;
   } cmd_type;

endpackage

// ===== rtl/core/ogu_ctrl.sv =====
// ----------------------------------------------------------------------------
// ogu_ctrl
// Sequencer: steps one item through index reduction, memory read-modify-write,
// percent search and the result register handoff.
// ----------------------------------------------------------------------------
module ogu_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output ogu_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_QM,
      S_SUB,
      S_READ,
      S_APPLY,
      S_SEARCH,
      S_DONE
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] bit_ff, bit_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // Result register can take a new result
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Decode commands from the current state
   always_comb begin
      cmd            = '0;
      cmd.capture    = (state_ff == S_IDLE) && req_tvalid;
      cmd.mod_mul    = (state_ff == S_MUL);
      cmd.mod_qm     = (state_ff == S_QM);
      cmd.mod_sub    = (state_ff == S_SUB);
      cmd.mem_read   = (state_ff == S_READ);
      cmd.apply      = (state_ff == S_APPLY);
      cmd.search     = (state_ff == S_SEARCH);
      cmd.search_bit = bit_ff;
      cmd.out_load   = (state_ff == S_DONE) && out_free;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      bit_in   = bit_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_MUL;
            end
         end
         S_MUL:   state_in = S_QM;
         S_QM:    state_in = S_SUB;
         S_SUB:   state_in = S_READ;
         S_READ:  state_in = S_APPLY;
         S_APPLY: begin
            state_in = S_SEARCH;
            bit_in   = 3'd6;
         end
         S_SEARCH: begin
            if (bit_ff == 3'd0) begin
               state_in = S_DONE;
            end else begin
               bit_in = bit_ff - 3'd1;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold result valid until the downstream transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bit_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // A transfer in starts the sequence and closes the input
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (!req_tready && state_ff == S_MUL))
      else $error("accepted item did not start the sequence");

   // At most one datapath step per cycle
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.mod_mul, cmd.mod_qm, cmd.mod_sub,
                cmd.mem_read, cmd.apply, cmd.search, cmd.out_load}))
      else $error("overlapping datapath steps");

   // The search ends after its lowest bit
   a_search_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH && bit_ff == 3'd0) |=> (state_ff == S_DONE))
      else $error("percent search did not finish");

   // A new result only comes out of the done step
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the done step");

endmodule

// ===== rtl/core/ogu_datapath.sv =====
// ----------------------------------------------------------------------------
// ogu_datapath
// Configuration registers, cell store, index reduction, inverse sensor model,
// saturating log-odds update, percent search and result register.
// ----------------------------------------------------------------------------
module ogu_datapath #(
   parameter int MAP_CELLS = ogu_pkg::MAP_CELLS_DEFAULT,
   parameter int LOG_WIDTH = ogu_pkg::LOG_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ogu_pkg::cmd_type                  cmd,
   input  logic [63:0]                       req_tdata,
   input  logic                              req_tuser,
   output logic [23:0]                       rsp_tdata,
   output logic [1:0]                        rsp_tuser,
   input  logic                              csr_write,
   input  logic [ogu_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ogu_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int ADDR_W = $clog2(MAP_CELLS);
   localparam int CMP_W  = (LOG_WIDTH > ogu_pkg::EDGE_W) ? LOG_WIDTH : ogu_pkg::EDGE_W;
   localparam int SUM_W  = CMP_W + 2;
   localparam logic [31:0] MOD_DIV   = 32'(MAP_CELLS);
   localparam logic [31:0] MOD_RECIP = 32'((64'd1 << 32) / MAP_CELLS);
   localparam logic signed [SUM_W-1:0] LOG_MAX =
      {{(SUM_W-LOG_WIDTH+1){1'b0}}, {(LOG_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] LOG_MIN =
      {{(SUM_W-LOG_WIDTH+1){1'b1}}, {(LOG_WIDTH-1){1'b0}}};

   // Configuration registers
   logic [15:0]                      range_ff, band_ff, self_ff;
   logic signed [15:0]               init_ff, occ_ff, free_ff;
   logic [ogu_pkg::PCT_W-1:0]        thr_ff;

   // Captured item
   logic                             func_ff;
   logic [15:0]                      idx_ff, dist_ff, beam_a_ff, beam_b_ff;

   // Index reduction
   logic [47:0]                      prod_ff;
   logic [16:0]                      qm_ff;
   logic [ADDR_W-1:0]                slot_ff;
   logic [16:0]                      rem;
   logic [31:0]                      rem_ext;

   // Geometry and sensor model
   logic                             far_ff, near_ff;
   logic [16:0]                      beam_ff;
   logic signed [15:0]               term_ff, term_in;
   logic [17:0]                      reach, lim;
   logic [16:0]                      dist_ext, diff;
   logic                             beyond, in_sensor, close;

   // Store and update
   logic [LOG_WIDTH-1:0]             mem [MAP_CELLS];
   logic signed [LOG_WIDTH-1:0]      rd_ff;
   logic signed [LOG_WIDTH-1:0]      value_ff, value_in, sat_val;
   logic signed [SUM_W-1:0]          pre;
   logic [1:0]                       region_ff, region_in;
   logic                             mem_we;

   // Percent search
   logic [ogu_pkg::PCT_W-1:0]        pct_ff, cand, pct_out;
   logic signed [CMP_W-1:0]          edge_cmp, value_cmp;

   // Result register
   logic [23:0]                      rsp_data_ff;
   logic [1:0]                       rsp_user_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff <= ogu_pkg::RST_SENSOR_RANGE;
         band_ff  <= ogu_pkg::RST_OCCUPIED_BAND;
         self_ff  <= ogu_pkg::RST_SELF_RADIUS;
         init_ff  <= ogu_pkg::RST_LOG_INITIAL;
         occ_ff   <= ogu_pkg::RST_LOG_OCCUPIED;
         free_ff  <= ogu_pkg::RST_LOG_FREE;
         thr_ff   <= ogu_pkg::RST_THRESHOLD;
      end else if (csr_write) begin
         case (csr_index)
            ogu_pkg::CSR_SENSOR_RANGE:  range_ff <= csr_data;
            ogu_pkg::CSR_OCCUPIED_BAND: band_ff  <= csr_data;
            ogu_pkg::CSR_SELF_RADIUS:   self_ff  <= csr_data;
            ogu_pkg::CSR_LOG_INITIAL:   init_ff  <= signed'(csr_data);
            ogu_pkg::CSR_LOG_OCCUPIED:  occ_ff   <= signed'(csr_data);
            ogu_pkg::CSR_LOG_FREE:      free_ff  <= signed'(csr_data);
            ogu_pkg::CSR_THRESHOLD:     thr_ff   <= csr_data[ogu_pkg::PCT_W-1:0];
            default: ;
         endcase
      end
   end

   // Reduce the cell index modulo the store depth
   assign rem     = {1'b0, idx_ff} - qm_ff;
   assign rem_ext = {15'd0, rem};

   // Inverse sensor model term
   assign dist_ext  = {1'b0, dist_ff};
   assign reach     = {1'b0, beam_ff} + {2'b0, band_ff};
   assign lim       = ({2'b0, range_ff} < reach) ? {2'b0, range_ff} : reach;
   assign beyond    = {2'b0, dist_ff} > lim;
   assign diff      = (dist_ext > beam_ff) ? (dist_ext - beam_ff) : (beam_ff - dist_ext);
   assign in_sensor = beam_ff < {1'b0, range_ff};
   assign close     = diff < {1'b0, band_ff};

   always_comb begin
      if (beyond) begin
         term_in = init_ff;
      end else if (in_sensor && close) begin
         term_in = occ_ff;
      end else if (in_sensor) begin
         term_in = free_ff;
      end else begin
         term_in = init_ff;
      end
   end

   // Capture, reduce, classify
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff   <= req_tuser;
         idx_ff    <= req_tdata[15:0];
         dist_ff   <= req_tdata[31:16];
         beam_a_ff <= req_tdata[47:32];
         beam_b_ff <= req_tdata[63:48];
      end
      if (cmd.mod_mul) begin
         prod_ff <= {32'd0, idx_ff} * {16'd0, MOD_RECIP};
         far_ff  <= {1'b0, dist_ff} > ({1'b0, range_ff} + {1'b0, band_ff});
         near_ff <= dist_ff < self_ff;
         beam_ff <= ((beam_a_ff < beam_b_ff) ? {1'b0, beam_a_ff} : {1'b0, beam_b_ff})
                    + ogu_pkg::BEAM_OFFSET;
      end
      if (cmd.mod_qm) begin
         qm_ff   <= 17'({32'd0, prod_ff[47:32]} * {16'd0, MOD_DIV});
         term_ff <= term_in;
      end
      if (cmd.mod_sub) begin
         slot_ff <= ADDR_W'((rem_ext >= MOD_DIV) ? (rem_ext - MOD_DIV) : rem_ext);
      end
   end

   // Saturating update of the stored log-odds, or the initial value for an init item
   always_comb begin
      if (func_ff) begin
         pre = SUM_W'(init_ff);
      end else begin
         pre = SUM_W'(rd_ff) + SUM_W'(term_ff) - SUM_W'(init_ff);
      end
      if (pre > LOG_MAX) begin
         sat_val = LOG_MAX[LOG_WIDTH-1:0];
      end else if (pre < LOG_MIN) begin
         sat_val = LOG_MIN[LOG_WIDTH-1:0];
      end else begin
         sat_val = pre[LOG_WIDTH-1:0];
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      value_in  = rd_ff;
      region_in = ogu_pkg::REGION_OUT;
      if (func_ff) begin
         mem_we    = cmd.apply;
         value_in  = sat_val;
         region_in = ogu_pkg::REGION_INIT;
      end else if (far_ff) begin
         region_in = ogu_pkg::REGION_OUT;
      end else if (near_ff) begin
         region_in = ogu_pkg::REGION_BODY;
      end else begin
         mem_we    = cmd.apply;
         value_in  = sat_val;
         region_in = ogu_pkg::REGION_UPDATE;
      end
   end

   // Cell store: one write port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[slot_ff] <= value_in;
      end
      if (cmd.mem_read) begin
         rd_ff <= mem[slot_ff];
      end
   end

   // Binary search of the percent table, one bit per step
   assign cand      = pct_ff | (7'd1 << cmd.search_bit);
   assign edge_cmp  = CMP_W'(ogu_pkg::pct_edge_at(cand - 7'd1));
   assign value_cmp = CMP_W'(value_ff);

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         value_ff  <= value_in;
         region_ff <= region_in;
         pct_ff    <= '0;
      end else if (cmd.search) begin
         if ((cand <= ogu_pkg::PCT_MAX) && (edge_cmp <= value_cmp)) begin
            pct_ff <= cand;
         end
      end
   end

   // Load the result register; the robot body reads as free
   assign pct_out = (region_ff == ogu_pkg::REGION_BODY) ? '0 : pct_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= {(pct_out >= thr_ff), pct_out, idx_ff};
         rsp_user_ff <= region_ff;
      end
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule

// ===== rtl/core/occupancy_grid_log_odds_update.sv =====
// ----------------------------------------------------------------------------
// occupancy_grid_log_odds_update
// Per-cell log-odds occupancy update with inverse sensor model and percent out.
// ----------------------------------------------------------------------------
// One item is handled at a time. After its input transfer it steps through
// the index reduction modulo the store depth (reciprocal multiply, product
// back, correct), a read of the cell store, the saturating update and the
// write-back of the cell, the bitwise binary search over the 100-entry
// percent table and the load of the result register. A finished result waits
// in its own register, so the next item is taken while it is still unread;
// the block only stalls in the load step when the previous result is still
// held.
// The store has no reset and no clearing pass: a cell must be written by an
// init item before an update or out-of-range item reads it. Configuration
// writes are taken every cycle and belong in idle periods.
// ----------------------------------------------------------------------------
module occupancy_grid_log_odds_update #(
   parameter int MAP_CELLS = ogu_pkg::MAP_CELLS_DEFAULT,
   parameter int LOG_WIDTH = ogu_pkg::LOG_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input item
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [15:0] cell_index, [31:16] cell_distance, [47:32] beam_range_a,
   // [63:48] beam_range_b
   input  logic [63:0]                     req_tdata,
   // [0] func
   input  logic                            req_tuser,
   // Result item
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [15:0] cell_number, [22:16] occupancy_percent, [23] occupied_flag
   output logic [23:0]                     rsp_tdata,
   // [1:0] region_code
   output logic [1:0]                      rsp_tuser,
   // Configuration write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ogu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ogu_pkg::CSR_DATA_W-1:0]  csr_data
);

   ogu_pkg::cmd_type cmd;
   logic             csr_write;

   // Registers take a write every cycle
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   ogu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   ogu_datapath #(
      .MAP_CELLS (MAP_CELLS),
      .LOG_WIDTH (LOG_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule
